// ===== design/vna_pkg.sv =====
`timescale 1ns / 1ps

package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   localparam int COUNT_W = 11;
   localparam int IDX_W = 10;
   localparam int COORD_W = 32;
   localparam int SUM_W = 32;
   localparam int NORM_W = 16;
   localparam int Q_W = 15;
   localparam int STEP_W = 5;

   localparam int CROSS_TERMS = 6;
   localparam int SQ_TERMS = 3;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 15;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      SEL_A,
      SEL_B,
      SEL_C,
      SEL_SLOT,
      SEL_CLR
   } addr_sel_type;

   typedef enum logic {
      VSRC_CROSS,
      VSRC_SUM
   } vsrc_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_EDGE,
      ST_SCALE,
      ST_CROSS,
      ST_CROSS_END,
      ST_SUM_RD,
      ST_NORM_LOAD,
      ST_NORM,
      ST_SQUARE,
      ST_SQ_END,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic         cap_req;
      logic         pos_wr;
      logic         clr_wr;
      logic         sum_wr;
      addr_sel_type addr_sel;
      addr_type     clr_addr;
      logic         lat_a;
      logic         lat_b;
      logic         edge_en;
      logic         scale_en;
      logic         acc_clr;
      logic         mul_en;
      logic         mul_sq;
      logic [2:0]   mul_step;
      logic         norm_load;
      vsrc_type     vsrc;
      logic         norm_step;
      logic         sqrt_init;
      logic         sqrt_step;
      logic         div_init;
      logic         div_step;
      logic         set_err;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       bad_corner;
      logic       vec_zero;
      logic       norm_done;
   } status_type;

endpackage

// ===== design/vna_if.sv =====
`timescale 1ns / 1ps

interface vna_req_if;
   import vna_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [IDX_W-1:0]          vertex_slot;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic [IDX_W-1:0]          corner_a;
   logic [IDX_W-1:0]          corner_b;
   logic [IDX_W-1:0]          corner_c;

   modport source (
      output valid, mode, vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
      input  ready
   );
   modport sink (
      input  valid, mode, vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
      output ready
   );
endinterface

interface vna_rsp_if;
   import vna_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic signed [NORM_W-1:0] normal_z;
   logic                     index_error;

   modport source (
      output valid, normal_x, normal_y, normal_z, index_error,
      input  ready
   );
   modport sink (
      input  valid, normal_x, normal_y, normal_z, index_error,
      output ready
   );
endinterface

// ===== design/vna_ctrl.sv =====
`timescale 1ns / 1ps

module vna_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  vna_pkg::status_type  status,
   output vna_pkg::cmd_type     cmd
);
   import vna_pkg::*;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         corner_ff, corner_in;
   addr_type           clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   state_type          finish_state;
   addr_sel_type       corner_sel;

   // after the unit vector: read-out goes to the output, a face goes to the scatter-add
   assign finish_state = (status.mode == MODE_READ) ? ST_OUT : ST_ACC_RD;

   always_comb begin
      case (corner_ff)
         2'd0:    corner_sel = SEL_A;
         2'd1:    corner_sel = SEL_B;
         default: corner_sel = SEL_C;
      endcase
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      step_in   = '0;
      corner_in = '0;
      clr_in    = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == addr_type'(MAX_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.mode == MODE_TRI && !status.bad_corner) state_in = ST_RD_A;
            else if (status.mode == MODE_READ) state_in = ST_SUM_RD;
            else state_in = ST_IDLE;
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_C;
         ST_RD_C: state_in = ST_EDGE;
         ST_EDGE: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_CROSS;
         ST_CROSS: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CROSS_TERMS - 1)) state_in = ST_CROSS_END;
         end
         ST_CROSS_END: state_in = ST_NORM_LOAD;
         ST_SUM_RD: state_in = ST_NORM_LOAD;
         ST_NORM_LOAD: state_in = ST_NORM;
         ST_NORM: begin
            if (status.vec_zero) state_in = finish_state;
            else if (status.norm_done) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_TERMS - 1)) state_in = ST_SQ_END;
         end
         ST_SQ_END: state_in = ST_SQRT_INIT;
         ST_SQRT_INIT: state_in = ST_SQRT;
         ST_SQRT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = finish_state;
         end
         ST_ACC_RD: begin
            corner_in = corner_ff;
            state_in  = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            corner_in = corner_ff + 1'b1;
            if (corner_ff == 2'd2) state_in = ST_IDLE;
            else state_in = ST_ACC_RD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = SEL_A;
      cmd.vsrc     = VSRC_CROSS;
      cmd.clr_addr = clr_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr   = 1'b1;
            cmd.addr_sel = SEL_CLR;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.cap_req = req_valid;
         end
         ST_DISPATCH: begin
            cmd.addr_sel = SEL_SLOT;
            cmd.pos_wr   = (status.mode == MODE_LOAD);
            cmd.set_err  = (status.mode == MODE_TRI) && status.bad_corner;
         end
         ST_RD_A: cmd.addr_sel = SEL_A;
         ST_RD_B: begin
            cmd.addr_sel = SEL_B;
            cmd.lat_a    = 1'b1;
         end
         ST_RD_C: begin
            cmd.addr_sel = SEL_C;
            cmd.lat_b    = 1'b1;
         end
         ST_EDGE: begin
            cmd.edge_en = 1'b1;
            cmd.acc_clr = 1'b1;
         end
         ST_SCALE: cmd.scale_en = 1'b1;
         ST_CROSS: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = step_ff[2:0];
         end
         ST_SUM_RD: cmd.addr_sel = SEL_SLOT;
         ST_NORM_LOAD: begin
            cmd.norm_load = 1'b1;
            cmd.acc_clr   = 1'b1;
            cmd.vsrc      = (status.mode == MODE_READ) ? VSRC_SUM : VSRC_CROSS;
         end
         ST_NORM: cmd.norm_step = !status.vec_zero && !status.norm_done;
         ST_SQUARE: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sq   = 1'b1;
            cmd.mul_step = step_ff[2:0];
         end
         ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
         ST_SQRT: cmd.sqrt_step = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_ACC_RD: cmd.addr_sel = corner_sel;
         ST_ACC_WR: begin
            cmd.addr_sel = corner_sel;
            cmd.sum_wr   = 1'b1;
         end
         ST_OUT: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         corner_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         corner_ff    <= corner_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/vna_dp.sv =====
`timescale 1ns / 1ps

module vna_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  vna_pkg::cmd_type                  cmd,
   output vna_pkg::status_type               status,
   input  logic                              csr_wr_en,
   input  logic [vna_pkg::COUNT_W-1:0]       csr_wr_data,
   input  logic [1:0]                        req_mode,
   input  logic [vna_pkg::IDX_W-1:0]         req_vertex_slot,
   input  logic signed [vna_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [vna_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [vna_pkg::COORD_W-1:0] req_pos_z,
   input  logic [vna_pkg::IDX_W-1:0]         req_corner_a,
   input  logic [vna_pkg::IDX_W-1:0]         req_corner_b,
   input  logic [vna_pkg::IDX_W-1:0]         req_corner_c,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_z,
   output logic                              rsp_index_error
);
   import vna_pkg::*;

   localparam int VEC_W = 3 * COORD_W;
   localparam int EDGE_W = COORD_W + 1;
   localparam int ES_W = 31;
   localparam int WIDE_W = 64;
   localparam int NUM_W = 45;

   // configuration and sticky error
   logic [COUNT_W-1:0] vcount_ff;
   logic               err_ff;

   // captured request
   logic [1:0]          mode_ff;
   logic [IDX_W-1:0]    slot_ff, ca_ff, cb_ff, cc_ff;
   logic [VEC_W-1:0]    pos_ff;

   // memories
   logic [VEC_W-1:0] pos_mem [MAX_VERTICES];
   logic [VEC_W-1:0] sum_mem [MAX_VERTICES];
   logic [VEC_W-1:0] pos_q_ff, sum_q_ff;
   logic [VEC_W-1:0] sum_wdata;
   addr_type         addr;
   logic             slot_ok, pos_we, sum_we;

   logic [VEC_W-1:0] pa_ff, pb_ff;

   logic signed [EDGE_W-1:0] edge_ff [6];
   logic signed [EDGE_W-1:0] edge_in [6];
   logic [EDGE_W-1:0]        emag [6];
   logic [EDGE_W-1:0]        eor;
   logic [1:0]               esh;
   logic signed [ES_W-1:0]   es_ff [6];
   logic signed [ES_W-1:0]   es_in [6];

   logic signed [31:0]       mul_a, mul_b;
   logic signed [WIDE_W-1:0] prod_ff;
   logic                     mvld_ff, msq_ff;
   logic [2:0]               mstep_ff;
   logic signed [WIDE_W-1:0] cr_ff [3];
   logic [WIDE_W-1:0]        ss_ff;

   logic signed [WIDE_W-1:0] vec [3];
   logic [WIDE_W-1:0]        m_ff [3];
   logic [2:0]               sgn_ff;
   logic [WIDE_W-1:0]        mor;

   logic [WIDE_W-1:0] x_ff, r_ff, bit_ff, sq_t;
   logic              sq_ge;
   logic [31:0]       len;

   logic [NUM_W-1:0]       num [3];
   logic [32:0]            rem_ff [3];
   logic [32:0]            rem2 [3];
   logic [Q_W-1:0]         low_ff [3];
   logic [Q_W-1:0]         q_ff [3];
   logic signed [NORM_W-1:0] fv [3];
   logic signed [32:0]     s33 [3];
   logic [SUM_W-1:0]       sat [3];

   assign slot_ok = 32'(slot_ff) < MAX_VERTICES;

   always_comb begin
      case (cmd.addr_sel)
         SEL_A:    addr = addr_type'(ca_ff);
         SEL_B:    addr = addr_type'(cb_ff);
         SEL_C:    addr = addr_type'(cc_ff);
         SEL_SLOT: addr = addr_type'(slot_ff);
         SEL_CLR:  addr = cmd.clr_addr;
         default:  addr = '0;
      endcase
   end

   assign pos_we    = cmd.pos_wr & slot_ok;
   assign sum_we    = cmd.clr_wr | pos_we | cmd.sum_wr;
   assign sum_wdata = cmd.sum_wr ? {sat[0], sat[1], sat[2]} : '0;

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[addr] <= pos_ff;
      pos_q_ff <= pos_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[addr] <= sum_wdata;
      sum_q_ff <= sum_mem[addr];
   end

   // edges against corner a; pos_q holds corner c while edges are formed
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         edge_in[i] = EDGE_W'(signed'(pb_ff[(2-i)*COORD_W +: COORD_W]))
                    - EDGE_W'(signed'(pa_ff[(2-i)*COORD_W +: COORD_W]));
         edge_in[i+3] = EDGE_W'(signed'(pos_q_ff[(2-i)*COORD_W +: COORD_W]))
                      - EDGE_W'(signed'(pa_ff[(2-i)*COORD_W +: COORD_W]));
      end
   end

   // scale all edges by a common right shift so that every magnitude is below 2^30
   always_comb begin
      eor = '0;
      for (int i = 0; i < 6; i++) begin
         emag[i] = edge_ff[i][EDGE_W-1] ? EDGE_W'(-edge_ff[i]) : EDGE_W'(edge_ff[i]);
         eor     = eor | emag[i];
      end
      if (eor[32]) esh = 2'd3;
      else if (eor[31]) esh = 2'd2;
      else if (eor[30]) esh = 2'd1;
      else esh = 2'd0;
      for (int i = 0; i < 6; i++) begin
         es_in[i] = edge_ff[i][EDGE_W-1] ? -ES_W'(emag[i] >> esh) : ES_W'(emag[i] >> esh);
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case ({cmd.mul_sq, cmd.mul_step})
         4'b0_000: begin mul_a = 32'(es_ff[1]); mul_b = 32'(es_ff[5]); end
         4'b0_001: begin mul_a = 32'(es_ff[2]); mul_b = 32'(es_ff[4]); end
         4'b0_010: begin mul_a = 32'(es_ff[2]); mul_b = 32'(es_ff[3]); end
         4'b0_011: begin mul_a = 32'(es_ff[0]); mul_b = 32'(es_ff[5]); end
         4'b0_100: begin mul_a = 32'(es_ff[0]); mul_b = 32'(es_ff[4]); end
         4'b0_101: begin mul_a = 32'(es_ff[1]); mul_b = 32'(es_ff[3]); end
         4'b1_000: begin mul_a = signed'(m_ff[0][31:0]); mul_b = signed'(m_ff[0][31:0]); end
         4'b1_001: begin mul_a = signed'(m_ff[1][31:0]); mul_b = signed'(m_ff[1][31:0]); end
         4'b1_010: begin mul_a = signed'(m_ff[2][31:0]); mul_b = signed'(m_ff[2][31:0]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (cmd.vsrc == VSRC_SUM)
            vec[k] = slot_ok ? WIDE_W'(signed'(sum_q_ff[(2-k)*SUM_W +: SUM_W])) : '0;
         else
            vec[k] = cr_ff[k];
      end
   end

   assign mor = m_ff[0] | m_ff[1] | m_ff[2];
   assign len = r_ff[31:0];

   assign sq_t  = r_ff + bit_ff;
   assign sq_ge = x_ff >= sq_t;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k]  = (NUM_W'(m_ff[k][29:0]) << 14) + NUM_W'(len[31:1]);
         rem2[k] = {rem_ff[k][31:0], low_ff[k][Q_W-1]};
         fv[k]   = sgn_ff[k] ? -NORM_W'({1'b0, q_ff[k]}) : NORM_W'({1'b0, q_ff[k]});
         s33[k]  = 33'(signed'(sum_q_ff[(2-k)*SUM_W +: SUM_W])) + 33'(fv[k]);
         if (s33[k][32] != s33[k][31])
            sat[k] = s33[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else
            sat[k] = s33[k][31:0];
      end
   end

   assign status.mode       = mode_ff;
   assign status.bad_corner = ({1'b0, ca_ff} >= vcount_ff) || ({1'b0, cb_ff} >= vcount_ff)
                           || ({1'b0, cc_ff} >= vcount_ff) || (32'(ca_ff) >= MAX_VERTICES)
                           || (32'(cb_ff) >= MAX_VERTICES) || (32'(cc_ff) >= MAX_VERTICES);
   assign status.vec_zero   = (mor == '0);
   assign status.norm_done  = (mor[63:30] == '0) && mor[29];

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         err_ff    <= 1'b0;
         mvld_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) vcount_ff <= csr_wr_data;
         if (cmd.set_err) err_ff <= 1'b1;
         mvld_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         mode_ff <= req_mode;
         slot_ff <= req_vertex_slot;
         pos_ff  <= {req_pos_x, req_pos_y, req_pos_z};
         ca_ff   <= req_corner_a;
         cb_ff   <= req_corner_b;
         cc_ff   <= req_corner_c;
      end
      if (cmd.lat_a) pa_ff <= pos_q_ff;
      if (cmd.lat_b) pb_ff <= pos_q_ff;
      if (cmd.edge_en) edge_ff <= edge_in;
      if (cmd.scale_en) es_ff <= es_in;

      prod_ff  <= mul_a * mul_b;
      msq_ff   <= cmd.mul_sq;
      mstep_ff <= cmd.mul_step;

      // accumulate one registered product a cycle
      if (cmd.acc_clr) begin
         for (int k = 0; k < 3; k++) cr_ff[k] <= '0;
         ss_ff <= '0;
      end else if (mvld_ff) begin
         case ({msq_ff, mstep_ff})
            4'b0_000: cr_ff[0] <= cr_ff[0] + prod_ff;
            4'b0_001: cr_ff[0] <= cr_ff[0] - prod_ff;
            4'b0_010: cr_ff[1] <= cr_ff[1] + prod_ff;
            4'b0_011: cr_ff[1] <= cr_ff[1] - prod_ff;
            4'b0_100: cr_ff[2] <= cr_ff[2] + prod_ff;
            4'b0_101: cr_ff[2] <= cr_ff[2] - prod_ff;
            default:  ss_ff <= ss_ff + unsigned'(prod_ff);
         endcase
      end

      // normalizing shift: coarse steps of eight, then single bits
      if (cmd.norm_load) begin
         for (int k = 0; k < 3; k++) begin
            sgn_ff[k] <= vec[k][WIDE_W-1];
            m_ff[k]   <= vec[k][WIDE_W-1] ? WIDE_W'(-vec[k]) : WIDE_W'(vec[k]);
            q_ff[k]   <= '0;
         end
      end else if (cmd.norm_step) begin
         for (int k = 0; k < 3; k++) begin
            if (mor[63:37] != '0) m_ff[k] <= m_ff[k] >> 8;
            else if (mor[63:30] != '0) m_ff[k] <= m_ff[k] >> 1;
            else if (mor[63:22] == '0) m_ff[k] <= m_ff[k] << 8;
            else m_ff[k] <= m_ff[k] << 1;
         end
      end

      // integer square root, one result bit a cycle
      if (cmd.sqrt_init) begin
         x_ff   <= ss_ff;
         r_ff   <= '0;
         bit_ff <= WIDE_W'(1) << 62;
      end else if (cmd.sqrt_step) begin
         if (sq_ge) begin
            x_ff <= x_ff - sq_t;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      // three restoring dividers, one quotient bit a cycle
      if (cmd.div_init) begin
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= 33'(num[k][NUM_W-1:Q_W]);
            low_ff[k] <= num[k][Q_W-1:0];
            q_ff[k]   <= '0;
         end
      end else if (cmd.div_step) begin
         for (int k = 0; k < 3; k++) begin
            if (rem2[k] >= {1'b0, len}) begin
               rem_ff[k] <= rem2[k] - {1'b0, len};
               q_ff[k]   <= {q_ff[k][Q_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= rem2[k];
               q_ff[k]   <= {q_ff[k][Q_W-2:0], 1'b0};
            end
            low_ff[k] <= low_ff[k] << 1;
         end
      end

      if (cmd.out_load) begin
         rsp_normal_x    <= fv[0];
         rsp_normal_y    <= fv[1];
         rsp_normal_z    <= fv[2];
         rsp_index_error <= err_ff;
      end
   end

endmodule

// ===== design/vertex_normal_accumulate.sv =====
`timescale 1ns / 1ps

// Smooth vertex normals by scatter-add of unit face normals.
// req_chan carries one command per transfer: mode 0 loads a vertex position
// (Q16.16) and clears its normal sum, mode 1 adds a triangle's unit face
// normal (Q2.14) into its three corners, mode 2 reads back one vertex's
// normalized sum. Only mode 2 produces a transfer on rsp_chan; index_error
// there reports any triangle since reset with a corner at or beyond
// csr_wr_data as last written (vertex_count). Write the CSR only when idle.
// One item is worked at a time by a shared multiplier, a bit-serial square
// root and three bit-serial dividers. A load writes the position; a
// triangle and a read each normalize their vector by shift steps before
// the root and the division; a zero vector skips the root and the division.
// After reset the normal sums are swept to zero, one entry a cycle, over all
// MAX_VERTICES (1024) entries with req_chan.ready low; the CSR is taken then.
// The result sits in an output register: a stalled receiver holds it, and
// the next command is still accepted; only a second read result waits.
module vertex_normal_accumulate (
   input  logic                          clock,
   input  logic                          reset,
   vna_req_if.sink                       req_chan,
   vna_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [vna_pkg::COUNT_W-1:0]   csr_wr_data
);
   import vna_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the handshakes and every step of the work
   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, edge and cross product, normalize, root, divide, accumulate
   vna_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_mode        (req_chan.mode),
      .req_vertex_slot (req_chan.vertex_slot),
      .req_pos_x       (req_chan.pos_x),
      .req_pos_y       (req_chan.pos_y),
      .req_pos_z       (req_chan.pos_z),
      .req_corner_a    (req_chan.corner_a),
      .req_corner_b    (req_chan.corner_b),
      .req_corner_c    (req_chan.corner_c),
      .rsp_normal_x    (rsp_chan.normal_x),
      .rsp_normal_y    (rsp_chan.normal_y),
      .rsp_normal_z    (rsp_chan.normal_z),
      .rsp_index_error (rsp_chan.index_error)
   );

endmodule

// ===== design/vna_checker.sv =====
`timescale 1ns / 1ps

module vna_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [vna_pkg::NORM_W-1:0]   rsp_normal_x,
   input logic signed [vna_pkg::NORM_W-1:0]   rsp_normal_y,
   input logic signed [vna_pkg::NORM_W-1:0]   rsp_normal_z,
   input logic                                rsp_index_error
);
   import vna_pkg::*;

   logic seen_err_ff;

   always_ff @(posedge clock) begin
      if (reset) seen_err_ff <= 1'b0;
      else if (rsp_valid && rsp_ready && rsp_index_error) seen_err_ff <= 1'b1;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_normal_x) && $stable(rsp_normal_y)
                                  && $stable(rsp_normal_z) && $stable(rsp_index_error))
      else $error("response payload changed while stalled");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before sum clearing");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384
                 && rsp_normal_y >= -16'sd16384 && rsp_normal_y <= 16'sd16384
                 && rsp_normal_z >= -16'sd16384 && rsp_normal_z <= 16'sd16384)
      else $error("normal component beyond unit range");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_err_ff |-> rsp_index_error)
      else $error("index error flag cleared");

endmodule

bind vertex_normal_accumulate vna_checker u_vna_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_normal_x    (rsp_chan.normal_x),
   .rsp_normal_y    (rsp_chan.normal_y),
   .rsp_normal_z    (rsp_chan.normal_z),
   .rsp_index_error (rsp_chan.index_error)
);

// ===== dv/vertex_normal_accumulate_test.sv =====
`timescale 1ns / 1ps

module vertex_normal_accumulate_test;
   import vna_pkg::*;

   localparam logic [1:0] MODE_NONE = 2'd3;   // unused mode: no effect, no result
   localparam int DRAIN_CYCLES = 200;         // covers a triangle still in flight

   typedef enum logic { ROW_CMD, ROW_CSR } row_kind_e;

   typedef struct {
      logic [1:0]         mode;
      logic [IDX_W-1:0]   slot;
      logic [COORD_W-1:0] px, py, pz;
      logic [IDX_W-1:0]   ca, cb, cc;
   } cmd_t;

   typedef struct {
      logic signed [NORM_W-1:0] nx, ny, nz;
      logic                     err;
   } normal_t;

   typedef struct {
      row_kind_e         kind;
      cmd_t              cmd;
      logic [COUNT_W-1:0] count;
      bit                typed;
      normal_t           want;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   vna_req_if req_bus();
   vna_rsp_if rsp_bus();

   vertex_normal_accumulate dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block's state, updated as each command transfer is accepted.
   int      mesh_px [MAX_VERTICES];
   int      mesh_py [MAX_VERTICES];
   int      mesh_pz [MAX_VERTICES];
   int      acc_x [MAX_VERTICES];
   int      acc_y [MAX_VERTICES];
   int      acc_z [MAX_VERTICES];
   bit      loaded [MAX_VERTICES];
   bit      corner_fault;
   int      vertex_limit;

   normal_t normal_expect_q[$];
   int      fail_count;
   int      reads_seen;
   int      tris_sent;
   int      bad_tris_sent;
   bit      idle_on;

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag64(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Scale the largest magnitude into [2^29, 2^30), then divide by the
   // integer length with rounding; the sign is put back per component.
   function automatic void unit_q14(input longint cx, cy, cz,
                                    output longint nx, ny, nz);
      longint unsigned m0, m1, m2, big, len, q0, q1, q2;
      m0 = mag64(cx);
      m1 = mag64(cy);
      m2 = mag64(cz);
      big = m0;
      if (m1 > big) big = m1;
      if (m2 > big) big = m2;
      if (big == 0) begin
         nx = 0; ny = 0; nz = 0;
         return;
      end
      while (big >= (64'd1 << 30)) begin
         m0 >>= 1; m1 >>= 1; m2 >>= 1; big >>= 1;
      end
      while (big < (64'd1 << 29)) begin
         m0 <<= 1; m1 <<= 1; m2 <<= 1; big <<= 1;
      end
      len = root64(m0 * m0 + m1 * m1 + m2 * m2);
      q0 = (m0 * 16384 + len / 2) / len;
      q1 = (m1 * 16384 + len / 2) / len;
      q2 = (m2 * 16384 + len / 2) / len;
      nx = (cx < 0) ? -longint'(q0) : longint'(q0);
      ny = (cy < 0) ? -longint'(q1) : longint'(q1);
      nz = (cz < 0) ? -longint'(q2) : longint'(q2);
   endfunction

   function automatic int sat32(int s, longint d);
      longint r;
      r = longint'(s) + d;
      if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
      if (r < -64'sh80000000) r = -64'sh80000000;
      return int'(r);
   endfunction

   function automatic void add_face(int a, int b, int c);
      longint e[6];
      longint cx, cy, cz, fx, fy, fz;
      longint unsigned big, m;
      int sh;
      int k[3];
      e[0] = longint'(mesh_px[b]) - longint'(mesh_px[a]);
      e[1] = longint'(mesh_py[b]) - longint'(mesh_py[a]);
      e[2] = longint'(mesh_pz[b]) - longint'(mesh_pz[a]);
      e[3] = longint'(mesh_px[c]) - longint'(mesh_px[a]);
      e[4] = longint'(mesh_py[c]) - longint'(mesh_py[a]);
      e[5] = longint'(mesh_pz[c]) - longint'(mesh_pz[a]);
      big = 0;
      for (int i = 0; i < 6; i++) if (mag64(e[i]) > big) big = mag64(e[i]);
      sh = 0;
      while (big >= (64'd1 << 30)) begin
         big >>= 1;
         sh++;
      end
      // truncate toward zero, all edges by the same amount
      for (int i = 0; i < 6; i++) begin
         m = mag64(e[i]) >> sh;
         e[i] = (e[i] < 0) ? -longint'(m) : longint'(m);
      end
      cx = e[1] * e[5] - e[2] * e[4];
      cy = e[2] * e[3] - e[0] * e[5];
      cz = e[0] * e[4] - e[1] * e[3];
      unit_q14(cx, cy, cz, fx, fy, fz);
      k[0] = a; k[1] = b; k[2] = c;
      for (int i = 0; i < 3; i++) begin
         acc_x[k[i]] = sat32(acc_x[k[i]], fx);
         acc_y[k[i]] = sat32(acc_y[k[i]], fy);
         acc_z[k[i]] = sat32(acc_z[k[i]], fz);
      end
   endfunction

   // Apply one accepted command to the mirror; return 1 with the normal when
   // the command produces a result.
   function automatic bit predict_normal(cmd_t cmd, output normal_t res);
      longint nx, ny, nz;
      res = '{default: '0};
      case (cmd.mode)
         MODE_LOAD: begin
            mesh_px[cmd.slot] = cmd.px;
            mesh_py[cmd.slot] = cmd.py;
            mesh_pz[cmd.slot] = cmd.pz;
            acc_x[cmd.slot] = 0;
            acc_y[cmd.slot] = 0;
            acc_z[cmd.slot] = 0;
            loaded[cmd.slot] = 1'b1;
            return 1'b0;
         end
         MODE_TRI: begin
            if (cmd.ca >= vertex_limit || cmd.cb >= vertex_limit ||
                cmd.cc >= vertex_limit) begin
               corner_fault = 1'b1;
            end else begin
               add_face(cmd.ca, cmd.cb, cmd.cc);
            end
            return 1'b0;
         end
         MODE_READ: begin
            unit_q14(acc_x[cmd.slot], acc_y[cmd.slot], acc_z[cmd.slot], nx, ny, nz);
            res.nx = nx[NORM_W-1:0];
            res.ny = ny[NORM_W-1:0];
            res.nz = nz[NORM_W-1:0];
            res.err = corner_fault;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Present one command, hold it until the transfer, then advance the mirror.
   task automatic send_cmd(cmd_t cmd, bit typed, normal_t want);
      bit taken;
      normal_t res;
      while (idle_on && $urandom_range(0, 99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= cmd.mode;
      req_bus.vertex_slot <= cmd.slot;
      req_bus.pos_x <= cmd.px;
      req_bus.pos_y <= cmd.py;
      req_bus.pos_z <= cmd.pz;
      req_bus.corner_a <= cmd.ca;
      req_bus.corner_b <= cmd.cb;
      req_bus.corner_c <= cmd.cc;
      // sample the handshake mid-cycle, act on it at the next edge
      do begin
         @(negedge clock);
         taken = req_bus.valid && req_bus.ready;
         @(posedge clock);
      end while (!taken);
      if (cmd.mode == MODE_TRI) begin
         tris_sent++;
         if (cmd.ca >= vertex_limit || cmd.cb >= vertex_limit || cmd.cc >= vertex_limit)
            bad_tris_sent++;
      end
      if (predict_normal(cmd, res))
         normal_expect_q.push_back(typed ? want : res);
   endtask

   // Drain, let any triangle in flight finish, then change vertex_count.
   task automatic write_count(int value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (normal_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_limit = value;
   endtask

   function automatic cmd_t make_cmd(logic [1:0] mode, int slot, int px, int py, int pz,
                                     int a, int b, int c);
      cmd_t cmd;
      cmd.mode = mode;
      cmd.slot = IDX_W'(slot);
      cmd.px = px; cmd.py = py; cmd.pz = pz;
      cmd.ca = IDX_W'(a); cmd.cb = IDX_W'(b); cmd.cc = IDX_W'(c);
      return cmd;
   endfunction

   function automatic plan_row_t cmd_row(cmd_t cmd);
      plan_row_t r;
      r.kind = ROW_CMD;
      r.cmd = cmd;
      r.count = '0;
      r.typed = 1'b0;
      r.want = '{default: '0};
      return r;
   endfunction

   function automatic plan_row_t known_row(cmd_t cmd, int nx, int ny, int nz, bit err);
      plan_row_t r;
      r = cmd_row(cmd);
      r.typed = 1'b1;
      r.want.nx = NORM_W'(nx);
      r.want.ny = NORM_W'(ny);
      r.want.nz = NORM_W'(nz);
      r.want.err = err;
      return r;
   endfunction

   function automatic plan_row_t count_row(int value);
      plan_row_t r;
      r = cmd_row(make_cmd(MODE_NONE, 0, 0, 0, 0, 0, 0, 0));
      r.kind = ROW_CSR;
      r.count = COUNT_W'(value);
      return r;
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 3) == 0) return int'($urandom());
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   // Random command: mostly well-formed mesh traffic on loaded slots, with
   // bad corners, stray reads and the unused mode mixed in.
   function automatic cmd_t rand_cmd();
      int pick, slot_hi;
      int pool[$];
      int c0, c1, c2;
      slot_hi = (vertex_limit < 16) ? vertex_limit : 16;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < vertex_limit; i++) if (loaded[i]) pool.push_back(i);
      if (pick < 15 || (pick < 60 && pool.size() == 0)) begin
         if (slot_hi == 0 || $urandom_range(0, 4) == 0)
            return make_cmd(MODE_LOAD, $urandom_range(0, 1023), rand_coord(),
                            rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
         return make_cmd(MODE_LOAD, $urandom_range(0, slot_hi - 1), rand_coord(),
                         rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
      end
      if (pick < 60) begin
         c0 = pool[$urandom_range(0, pool.size() - 1)];
         c1 = pool[$urandom_range(0, pool.size() - 1)];
         c2 = pool[$urandom_range(0, pool.size() - 1)];
         return make_cmd(MODE_TRI, $urandom, $urandom, $urandom, $urandom, c0, c1, c2);
      end
      if (pick < 66 && vertex_limit < MAX_VERTICES) begin
         c0 = $urandom_range(vertex_limit, 1023);
         c1 = $urandom_range(0, 1023);
         c2 = $urandom_range(0, 1023);
         case ($urandom_range(0, 2))
            0: return make_cmd(MODE_TRI, $urandom, 0, 0, 0, c0, c1, c2);
            1: return make_cmd(MODE_TRI, $urandom, 0, 0, 0, c1, c0, c2);
            default: return make_cmd(MODE_TRI, $urandom, 0, 0, 0, c1, c2, c0);
         endcase
      end
      if (pick < 95) begin
         if (pool.size() != 0 && $urandom_range(0, 2) != 0)
            return make_cmd(MODE_READ, pool[$urandom_range(0, pool.size() - 1)],
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         return make_cmd(MODE_READ, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
      end
      return make_cmd(MODE_NONE, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
   endfunction

   // Receiver: drop ready about a quarter of the time while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !idle_on || ($urandom_range(0, 99) >= 24);
      end
   end

   // Check each read result against the oldest expected normal.
   always @(negedge clock) begin
      normal_t got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.nx = rsp_bus.normal_x;
         got.ny = rsp_bus.normal_y;
         got.nz = rsp_bus.normal_z;
         got.err = rsp_bus.index_error;
         reads_seen++;
         if (normal_expect_q.size() == 0) begin
            $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d err=%0b", $time,
                     got.nx, got.ny, got.nz, got.err);
            fail_count++;
         end else begin
            want = normal_expect_q.pop_front();
            if (got.nx !== want.nx) begin
               $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
               fail_count++;
            end
            if (got.ny !== want.ny) begin
               $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
               fail_count++;
            end
            if (got.nz !== want.nz) begin
               $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, got.nz);
               fail_count++;
            end
            if (got.err !== want.err) begin
               $display("%0t: index_error expected %0b actual %0b", $time, want.err, got.err);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      plan_row_t plan[$];
      int phase_limits[5];
      normal_t none;
      req_bus.valid = 1'b0;
      req_bus.mode = '0;
      req_bus.vertex_slot = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.corner_a = '0;
      req_bus.corner_b = '0;
      req_bus.corner_c = '0;
      rsp_bus.ready = 1'b0;
      none = '{default: '0};
      fail_count = 0;
      reads_seen = 0;
      tris_sent = 0;
      bad_tris_sent = 0;
      corner_fault = 1'b0;
      vertex_limit = 0;
      idle_on = 1'b1;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         mesh_px[i] = 0; mesh_py[i] = 0; mesh_pz[i] = 0;
         acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
         loaded[i] = 1'b0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // the block takes the CSR during its clearing sweep
      csr_wr_en <= 1'b1;
      csr_wr_data <= COUNT_W'(MAX_VERTICES);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_limit = MAX_VERTICES;

      // Directed: empty reads, a unit triangle and its reverse, extreme
      // coordinates, a degenerate face, the unused mode, bad corners.
      plan.push_back(known_row(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      plan.push_back(known_row(make_cmd(MODE_READ, 1023, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 1, 65536, 0, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 2, 0, 65536, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 0, 1, 2)));
      plan.push_back(known_row(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 0, 2, 1)));
      plan.push_back(known_row(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 3, 32'h7FFFFFFF, 32'h80000000,
                                      32'h7FFFFFFF, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 4, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 3, 4, 1)));
      plan.push_back(cmd_row(make_cmd(MODE_READ, 3, 0, 0, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_READ, 4, 0, 0, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 5, 32'h7FFFFFFF, 32'h80000000,
                                      32'h7FFFFFFF, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 3, 5, 4)));
      plan.push_back(known_row(make_cmd(MODE_READ, 5, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      plan.push_back(cmd_row(make_cmd(MODE_NONE, 1023, -1, -1, -1, 1023, 1023, 1023)));
      plan.push_back(cmd_row(make_cmd(MODE_LOAD, 1023, -1, -1, -1, 1023, 1023, 1023)));
      plan.push_back(known_row(make_cmd(MODE_READ, 1023, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      plan.push_back(count_row(3));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 0, 1, 3)));
      plan.push_back(known_row(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1));
      plan.push_back(count_row(0));
      plan.push_back(cmd_row(make_cmd(MODE_TRI, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(cmd_row(make_cmd(MODE_READ, 2, 0, 0, 0, 0, 0, 0)));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_count(plan[i].count);
         else send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
      end

      // Random phases across several vertex_count settings, the maximum included.
      phase_limits[0] = MAX_VERTICES;
      phase_limits[1] = $urandom_range(3, 40);
      phase_limits[2] = $urandom_range(1, 2);
      phase_limits[3] = $urandom_range(100, 1023);
      phase_limits[4] = MAX_VERTICES;
      for (int p = 0; p < 5; p++) begin
         write_count(phase_limits[p]);
         for (int n = 0; n < 110; n++) begin
            // hold both sides busy for a stretch in the middle of the fourth phase
            idle_on = !(p == 3 && n >= 20 && n < 90);
            send_cmd(rand_cmd(), 1'b0, none);
         end
      end
      idle_on = 1'b1;

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (normal_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d normal reads; sent %0d triangles (%0d with bad corners)",
               reads_seen, tris_sent, bad_tris_sent);
      $display("vertex_count settings swept from 0 to %0d with random idling on both sides",
               MAX_VERTICES);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
